// ===== rtl/linear_classifier_error_counter_macros.svh =====
// Assertion macros shared by the classifier RTL files.
`ifndef LINEAR_CLASSIFIER_ERROR_COUNTER_MACROS_SVH
`define LINEAR_CLASSIFIER_ERROR_COUNTER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LCEC_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LCEC_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/lcec_pkg.sv =====
// Types and constants shared by the linear classifier error counter.
package lcec_pkg;

  // Default depth of the weight store.
  localparam int MAX_FEATURES_DEF = 1024;

  // Field widths.
  localparam int IDX_W   = 10;
  localparam int VAL_W   = 32;
  localparam int ACC_W   = 64;
  localparam int CNT_W   = 32;
  localparam int IN_DW   = 48;
  localparam int OUT_DW  = 136;

  // Depth of the queue between the front and back parts.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  // Command codes carried on tuser.
  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_FEATURE = 2'd1,
    CMD_CLEAR   = 2'd2
  } cmd_t;

  // One word handed from the front part to the back part.
  typedef struct packed {
    logic               clear;
    logic               in_range;
    logic [VAL_W-1:0]   weight;
    logic [VAL_W-1:0]   operand;
    logic               label;
    logic               last;
  } q_entry_t;

endpackage

// ===== rtl/lcec_front.sv =====
// Front part: accepts input words, owns the weight store and fetches weights.
module lcec_front #(
  parameter int MAX_FEATURES = lcec_pkg::MAX_FEATURES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // s_tdata: feature_index [9:0], operand_value [41:10], true_label [42], zero pad
  input  logic [lcec_pkg::IN_DW-1:0]    s_tdata,
  // s_tuser: command [1:0]
  input  logic [1:0]                    s_tuser,
  input  logic                          s_tlast,
  output logic                          push,
  output lcec_pkg::q_entry_t            push_data,
  input  logic                          q_full
);

  localparam int AW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;

  logic [lcec_pkg::VAL_W-1:0] mem [MAX_FEATURES];

  logic [lcec_pkg::IDX_W-1:0] idx;
  logic [lcec_pkg::VAL_W-1:0] operand;
  logic                       in_range;
  logic [AW-1:0]              addr;
  logic                       accept;
  logic                       pass;
  lcec_pkg::cmd_t             cmd;

  logic                       st_valid;
  logic                       st_clear;
  logic                       st_in_range;
  logic [lcec_pkg::VAL_W-1:0] st_operand;
  logic                       st_label;
  logic                       st_last;
  logic [lcec_pkg::VAL_W-1:0] rdata;

  // Field decode.
  assign idx      = s_tdata[9:0];
  assign operand  = s_tdata[41:10];
  assign cmd      = lcec_pkg::cmd_t'(s_tuser);
  assign in_range = ({7'd0, idx} < 17'(MAX_FEATURES));
  assign addr     = AW'(idx);

  // A new word enters while the staging register is empty or draining.
  assign push     = st_valid && !q_full;
  assign s_tready = !st_valid || !q_full;
  assign accept   = s_tvalid && s_tready;

  // Only feature and clear words travel on to the back part.
  always_comb begin
    case (cmd)
      lcec_pkg::CMD_FEATURE: pass = 1'b1;
      lcec_pkg::CMD_CLEAR:   pass = 1'b1;
      default:               pass = 1'b0;
    endcase
  end

  // Weight store: written by load words, read with a registered port.
  always_ff @(posedge clk) begin
    if (accept && cmd == lcec_pkg::CMD_LOAD && in_range) begin
      mem[addr] <= operand;
    end
    if (accept) begin
      rdata <= mem[addr];
    end
  end

  // Staging register in front of the queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else if (accept) begin
      st_valid <= pass;
    end else if (push) begin
      st_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      st_clear    <= (cmd == lcec_pkg::CMD_CLEAR);
      st_in_range <= in_range;
      st_operand  <= operand;
      st_label    <= s_tdata[42];
      st_last     <= s_tlast;
    end
  end

  always_comb begin
    push_data.clear    = st_clear;
    push_data.in_range = st_in_range;
    push_data.weight   = rdata;
    push_data.operand  = st_operand;
    push_data.label    = st_label;
    push_data.last     = st_last;
  end

endmodule

// ===== rtl/lcec_fifo.sv =====
// Short queue that decouples the front part from the back part.
`include "linear_classifier_error_counter_macros.svh"
module lcec_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  lcec_pkg::q_entry_t  push_data,
  output logic                full,
  input  logic                pop,
  output lcec_pkg::q_entry_t  head,
  output logic                empty
);

  lcec_pkg::q_entry_t                entries [lcec_pkg::QUEUE_DEPTH];
  logic [lcec_pkg::QPTR_W-1:0]       wptr;
  logic [lcec_pkg::QPTR_W-1:0]       rptr;
  logic [lcec_pkg::QCNT_W-1:0]       count;

  assign full  = (count == lcec_pkg::QCNT_W'(lcec_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rptr];

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_data;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `LCEC_ASSERT_NOW(a_no_overflow, clk, rst, push, !full, "queue written while full")
  `LCEC_ASSERT_NOW(a_no_underflow, clk, rst, pop, !empty, "queue read while empty")

endmodule

// ===== rtl/lcec_back.sv =====
// Back part: multiply, accumulate, threshold compare and confusion counters.
`include "linear_classifier_error_counter_macros.svh"
module lcec_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_empty,
  input  lcec_pkg::q_entry_t            q_head,
  output logic                          pop,
  input  logic [lcec_pkg::VAL_W-1:0]    threshold,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // m_tdata: predicted_label [0], prediction_correct [1], true_positive_count [33:2],
  //          true_negative_count [65:34], false_positive_count [97:66],
  //          false_negative_count [129:98], zero pad
  output logic [lcec_pkg::OUT_DW-1:0]   m_tdata
);

  localparam logic [lcec_pkg::ACC_W-1:0] ACC_MAX = {1'b0, {(lcec_pkg::ACC_W-1){1'b1}}};
  localparam logic [lcec_pkg::ACC_W-1:0] ACC_MIN = {1'b1, {(lcec_pkg::ACC_W-1){1'b0}}};

  logic adv;

  // Multiply stage.
  logic signed [lcec_pkg::VAL_W-1:0] w_s;
  logic signed [lcec_pkg::VAL_W-1:0] op_s;
  logic signed [lcec_pkg::ACC_W-1:0] prod_c;
  logic                              s1_valid;
  logic                              s1_clear;
  logic                              s1_label;
  logic                              s1_last;
  logic [lcec_pkg::ACC_W-1:0]        s1_prod;

  // Accumulate stage.
  logic [lcec_pkg::ACC_W-1:0]        acc;
  logic [lcec_pkg::ACC_W-1:0]        raw_sum;
  logic [lcec_pkg::ACC_W-1:0]        sat_sum;
  logic                              ovf;
  logic                              s2_valid;
  logic                              s2_clear;
  logic                              s2_label;
  logic [lcec_pkg::ACC_W-1:0]        s2_sum;

  // Compare stage.
  logic [lcec_pkg::ACC_W-1:0]        thr64;
  logic                              s3_valid;
  logic                              s3_clear;
  logic                              s3_label;
  logic                              s3_pred;

  // Counter and output stage.
  logic [lcec_pkg::CNT_W-1:0]        tp;
  logic [lcec_pkg::CNT_W-1:0]        tn;
  logic [lcec_pkg::CNT_W-1:0]        fp;
  logic [lcec_pkg::CNT_W-1:0]        fn;
  logic                              out_pred;
  logic                              out_correct;

  // The whole back pipeline moves while the output word is free or being taken.
  assign adv = !m_tvalid || m_tready;
  assign pop = adv && !q_empty;

  assign w_s    = q_head.weight;
  assign op_s   = q_head.operand;
  assign prod_c = w_s * op_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_clear <= q_head.clear;
      s1_label <= q_head.label;
      s1_last  <= q_head.last;
      s1_prod  <= q_head.in_range ? prod_c : '0;
    end
  end

  // Saturating add into the accumulator; a finished point hands its sum on.
  assign raw_sum = acc + s1_prod;
  assign ovf     = (acc[lcec_pkg::ACC_W-1] == s1_prod[lcec_pkg::ACC_W-1]) &&
                   (raw_sum[lcec_pkg::ACC_W-1] != acc[lcec_pkg::ACC_W-1]);
  assign sat_sum = ovf ? (acc[lcec_pkg::ACC_W-1] ? ACC_MIN : ACC_MAX) : raw_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc      <= '0;
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid && (s1_clear || s1_last);
      if (s1_valid) begin
        if (s1_clear || s1_last) begin
          acc <= '0;
        end else begin
          acc <= sat_sum;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_clear <= s1_clear;
      s2_label <= s1_label;
      s2_sum   <= sat_sum;
    end
  end

  // Signed compare with the threshold widened to Q32.32.
  assign thr64 = {{16{threshold[lcec_pkg::VAL_W-1]}}, threshold, 16'd0};

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (adv) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_clear <= s2_clear;
      s3_label <= s2_label;
      s3_pred  <= ($signed(s2_sum) > $signed(thr64));
    end
  end

  // Confusion counters saturate at all ones; a clear zeroes them.
  always_ff @(posedge clk) begin
    if (rst) begin
      tp       <= '0;
      tn       <= '0;
      fp       <= '0;
      fn       <= '0;
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= s3_valid && !s3_clear;
      if (s3_valid) begin
        if (s3_clear) begin
          tp <= '0;
          tn <= '0;
          fp <= '0;
          fn <= '0;
        end else begin
          case ({s3_pred, s3_label})
            2'b11:   tp <= (&tp) ? tp : tp + 1'b1;
            2'b00:   tn <= (&tn) ? tn : tn + 1'b1;
            2'b10:   fp <= (&fp) ? fp : fp + 1'b1;
            default: fn <= (&fn) ? fn : fn + 1'b1;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_pred    <= s3_pred;
      out_correct <= (s3_pred == s3_label);
    end
  end

  assign m_tdata = {6'd0, fn, fp, tn, tp, out_correct, out_pred};

  `LCEC_ASSERT_NEXT(a_clear_zeroes, clk, rst, adv && s3_valid && s3_clear, (tp == '0) && (tn == '0) && (fp == '0) && (fn == '0), "counters not zero after clear")
  `LCEC_ASSERT_NEXT(a_counts_grow, clk, rst, adv && s3_valid && !s3_clear, (tp >= $past(tp)) && (tn >= $past(tn)) && (fp >= $past(fp)) && (fn >= $past(fn)), "counter went down without clear")

endmodule

// ===== rtl/linear_classifier_error_counter.sv =====
// Top level of the linear classifier with confusion counters.
//
//  Port group  Direction  Carries
//  s_*         in         command words: load weight, feature element, clear
//  m_*         out        one result word per last feature element
//  p*          in/out     threshold register, byte address 0
//
// Up to one word is accepted per cycle; a result leaves once its last feature
// element has passed the weight read, the queue and a four-stage multiply,
// accumulate, compare and count pipeline.
// Reset (rst, synchronous) empties all stages and zeroes the accumulator,
// counters and threshold; the weight store is not cleared.
// When m_tready is low the back pipeline holds and the four-word queue absorbs
// input until it fills, after which s_tready drops.
module linear_classifier_error_counter #(
  parameter int MAX_FEATURES = lcec_pkg::MAX_FEATURES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // s_tdata: feature_index [9:0], operand_value [41:10], true_label [42], zero pad
  input  logic [lcec_pkg::IN_DW-1:0]    s_tdata,
  // s_tuser: command [1:0]
  input  logic [1:0]                    s_tuser,
  input  logic                          s_tlast,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // m_tdata: predicted_label [0], prediction_correct [1], true_positive_count [33:2],
  //          true_negative_count [65:34], false_positive_count [97:66],
  //          false_negative_count [129:98], zero pad
  output logic [lcec_pkg::OUT_DW-1:0]   m_tdata,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  logic                       push;
  logic                       pop;
  logic                       q_full;
  logic                       q_empty;
  lcec_pkg::q_entry_t         push_data;
  lcec_pkg::q_entry_t         q_head;
  logic [lcec_pkg::VAL_W-1:0] threshold;

  // Threshold register.
  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= '0;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      threshold <= pwdata;
    end
  end

  lcec_front #(
    .MAX_FEATURES (MAX_FEATURES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  lcec_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  lcec_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .pop       (pop),
    .threshold (threshold),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule
